// ===== src/grid_lof_pkg.sv =====
// ----------------------------------------------------------------------------
// grid_lof_pkg
// Shared types and constants for the grid line-of-fire checker.
// ----------------------------------------------------------------------------
package grid_lof_pkg;

  localparam int CoordW = 6;   // width of one cell coordinate on the ports
  localparam int RegW   = 7;   // width of the grid size registers
  localparam int PosW   = 8;   // signed walk position, covers -1 .. 127
  localparam int DW     = 10;  // signed decision term

  // request command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_WALK,
    ST_SIDE1,
    ST_SIDE2,
    ST_DONE
  } state_t;

  // which cell the map read port looks at
  typedef enum logic [1:0] {
    RD_NEXT,
    RD_SIDE1,
    RD_SIDE2
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    wr_en;
    logic    clr_en;
    rd_sel_t rd_sel;
    logic    move;
    logic    res_set;
    logic    res_val;
    logic    out_push;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ends_ok;
    logic pos_in;
    logic at_tgt;
    logic blk;
    logic tie;
    logic side1_in;
    logic side2_in;
    logic out_free;
  } sts_t;

endpackage

// ===== src/grid_lof_ctrl.sv =====
// ----------------------------------------------------------------------------
// grid_lof_ctrl
// Sequencer for map clearing, cell writes and the line walk of a query.
// ----------------------------------------------------------------------------
module grid_lof_ctrl
  import grid_lof_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_cmd,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_QUERY) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        if (!sts.ends_ok || sts.at_tgt) state_nxt = ST_DONE;
        else if (sts.tie)               state_nxt = ST_SIDE1;
        else                            state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (!sts.pos_in || sts.at_tgt || sts.blk) state_nxt = ST_DONE;
        else if (sts.tie)                         state_nxt = ST_SIDE1;
        else                                      state_nxt = ST_WALK;
      end
      ST_SIDE1: begin
        if (sts.side1_in && sts.blk) state_nxt = ST_DONE;
        else                         state_nxt = ST_SIDE2;
      end
      ST_SIDE2: begin
        if (sts.side2_in && sts.blk) state_nxt = ST_DONE;
        else                         state_nxt = ST_WALK;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NEXT;
    in_stall   = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_QUERY) cmd.load  = 1'b1;
          else                     cmd.wr_en = 1'b1;
        end
      end
      ST_INIT: begin
        if (!sts.ends_ok) begin
          cmd.res_set = 1'b1;
        end else if (sts.at_tgt) begin
          cmd.res_set = 1'b1;
          cmd.res_val = 1'b1;
        end else if (sts.tie) begin
          cmd.rd_sel = RD_SIDE1;
        end else begin
          cmd.move = 1'b1;
        end
      end
      ST_WALK: begin
        if (!sts.pos_in) begin
          cmd.res_set = 1'b1;
        end else if (sts.at_tgt) begin
          cmd.res_set = 1'b1;
          cmd.res_val = 1'b1;
        end else if (sts.blk) begin
          cmd.res_set = 1'b1;
        end else if (sts.tie) begin
          cmd.rd_sel = RD_SIDE1;
        end else begin
          cmd.move = 1'b1;
        end
      end
      ST_SIDE1: begin
        if (sts.side1_in && sts.blk) cmd.res_set = 1'b1;
        else                         cmd.rd_sel  = RD_SIDE2;
      end
      ST_SIDE2: begin
        if (sts.side2_in && sts.blk) cmd.res_set = 1'b1;
        else                         cmd.move    = 1'b1;
      end
      ST_DONE: begin
        cmd.out_push = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== src/grid_lof_dp.sv =====
// ----------------------------------------------------------------------------
// grid_lof_dp
// Blocking map memory, grid size registers, walk position and decision term,
// result and output registers.
// ----------------------------------------------------------------------------
module grid_lof_dp
  import grid_lof_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [RegW-1:0]   cfg_wdata,
  input  logic [CoordW-1:0] in_cell_x,
  input  logic [CoordW-1:0] in_cell_y,
  input  logic              in_cell_blocks,
  input  logic [CoordW-1:0] in_from_x,
  input  logic [CoordW-1:0] in_from_y,
  input  logic [CoordW-1:0] in_to_x,
  input  logic [CoordW-1:0] in_to_y,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_line_clear,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int CAP   = (MAX_SIDE < 127) ? MAX_SIDE : 127;
  localparam logic [RegW-1:0] CAP_V  = RegW'(CAP);
  localparam logic [8:0]      MAXS_V = 9'(MAX_SIDE);

  function automatic logic in_range(logic signed [PosW-1:0] p, logic [RegW-1:0] side);
    return !p[PosW-1] && (p[RegW-1:0] < side);
  endfunction

  // ---- configuration ----
  logic [RegW-1:0] grid_w_r, grid_h_r;
  logic [RegW-1:0] side_w, side_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= RegW'(64);
      grid_h_r <= RegW'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_w_r <= cfg_wdata;
        REG_GRID_HEIGHT: grid_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign side_w = (grid_w_r > CAP_V) ? CAP_V : grid_w_r;
  assign side_h = (grid_h_r > CAP_V) ? CAP_V : grid_h_r;

  // ---- walk registers ----
  logic signed [PosW-1:0] pos_x_r, pos_y_r;
  logic [CoordW-1:0]      tgt_x_r, tgt_y_r;
  logic                   sx_neg_r, sy_neg_r;
  logic [RegW-1:0]        nx2_r, ny2_r;
  logic signed [DW-1:0]   d_r, d_nxt;

  logic signed [RegW-1:0] dx_w, dy_w;
  logic [RegW-1:0]        nx_w, ny_w;
  logic signed [DW-1:0]   d_init, nx2_ext, ny2_ext;

  assign dx_w = $signed({1'b0, in_to_x}) - $signed({1'b0, in_from_x});
  assign dy_w = $signed({1'b0, in_to_y}) - $signed({1'b0, in_from_y});
  assign nx_w = dx_w[RegW-1] ? RegW'(-dx_w) : RegW'(dx_w);
  assign ny_w = dy_w[RegW-1] ? RegW'(-dy_w) : RegW'(dy_w);
  assign d_init = $signed({{(DW-RegW){1'b0}}, ny_w}) - $signed({{(DW-RegW){1'b0}}, nx_w});

  assign nx2_ext = $signed({{(DW-RegW){1'b0}}, nx2_r});
  assign ny2_ext = $signed({{(DW-RegW){1'b0}}, ny2_r});

  // d < 0 steps x, d > 0 steps y, d == 0 steps both
  logic                   tie, step_x, step_y;
  logic signed [PosW-1:0] sx_v, sy_v, x_adj, y_adj, next_x, next_y;

  assign tie    = (d_r == '0);
  assign step_x = d_r[DW-1] || tie;
  assign step_y = !d_r[DW-1];
  assign sx_v   = sx_neg_r ? -PosW'(1) : PosW'(1);
  assign sy_v   = sy_neg_r ? -PosW'(1) : PosW'(1);
  assign x_adj  = pos_x_r + sx_v;
  assign y_adj  = pos_y_r + sy_v;
  assign next_x = step_x ? x_adj : pos_x_r;
  assign next_y = step_y ? y_adj : pos_y_r;

  always_comb begin
    d_nxt = d_r;
    if (step_x) d_nxt = d_nxt + ny2_ext;
    if (step_y) d_nxt = d_nxt - nx2_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_r  <= $signed({2'b00, in_from_x});
      pos_y_r  <= $signed({2'b00, in_from_y});
      tgt_x_r  <= in_to_x;
      tgt_y_r  <= in_to_y;
      sx_neg_r <= dx_w[RegW-1];
      sy_neg_r <= dy_w[RegW-1];
      nx2_r    <= {nx_w[RegW-2:0], 1'b0};
      ny2_r    <= {ny_w[RegW-2:0], 1'b0};
      d_r      <= d_init;
    end else if (cmd.move) begin
      pos_x_r <= next_x;
      pos_y_r <= next_y;
      d_r     <= d_nxt;
    end
  end

  // ---- blocking map ----
  logic                   mem [DEPTH];
  logic [AW-1:0]          clr_cnt_r;
  logic signed [PosW-1:0] rd_x, rd_y;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [PosW-1:0]        cell_x_ext, cell_y_ext;
  logic                   wr_ok, mem_we, wr_data, blk_r;

  always_comb begin
    case (cmd.rd_sel)
      RD_SIDE1: begin
        rd_x = x_adj;
        rd_y = pos_y_r;
      end
      RD_SIDE2: begin
        rd_x = pos_x_r;
        rd_y = y_adj;
      end
      default: begin
        rd_x = next_x;
        rd_y = next_y;
      end
    endcase
  end

  assign rd_addr    = {rd_y[CW-1:0], rd_x[CW-1:0]};
  assign cell_x_ext = {2'b00, in_cell_x};
  assign cell_y_ext = {2'b00, in_cell_y};
  assign wr_ok      = ({3'b000, in_cell_x} < MAXS_V) && ({3'b000, in_cell_y} < MAXS_V);
  assign mem_we     = cmd.clr_en || (cmd.wr_en && wr_ok);
  assign wr_addr    = cmd.clr_en ? clr_cnt_r : {cell_y_ext[CW-1:0], cell_x_ext[CW-1:0]};
  assign wr_data    = cmd.clr_en ? 1'b0 : in_cell_blocks;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    blk_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // ---- result and output register ----
  logic res_r, out_valid_r, out_line_clear_r;

  always_ff @(posedge clk) begin
    if (cmd.res_set) res_r <= cmd.res_val;
    if (cmd.out_push) out_line_clear_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_clear = out_line_clear_r;

  // ---- status ----
  logic signed [PosW-1:0] tgt_x_s, tgt_y_s;
  assign tgt_x_s = $signed({2'b00, tgt_x_r});
  assign tgt_y_s = $signed({2'b00, tgt_y_r});

  always_comb begin
    sts.clr_done = &clr_cnt_r;
    sts.pos_in   = in_range(pos_x_r, side_w) && in_range(pos_y_r, side_h);
    sts.ends_ok  = sts.pos_in && in_range(tgt_x_s, side_w) && in_range(tgt_y_s, side_h);
    sts.at_tgt   = (pos_x_r == tgt_x_s) && (pos_y_r == tgt_y_s);
    sts.blk      = blk_r;
    sts.tie      = tie;
    sts.side1_in = in_range(x_adj, side_w) && in_range(pos_y_r, side_h);
    sts.side2_in = in_range(pos_x_r, side_w) && in_range(y_adj, side_h);
    sts.out_free = !out_valid_r || !out_stall;
  end

endmodule

// ===== src/grid_line_of_fire_check.sv =====
// ----------------------------------------------------------------------------
// grid_line_of_fire_check
// Line-of-fire checker over a grid of blocking cells (supercover walk).
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (in_valid / in_stall): in_cmd = write stores in_cell_blocks
//    at (in_cell_x, in_cell_y); in_cmd = query walks from (in_from_x, in_from_y)
//    to (in_to_x, in_to_y). Only in_valid high and in_stall low takes a request.
//  - Result channel (out_valid / out_stall): one line_clear per query, none per
//    write. The result sits in an output register until taken.
//  - Config port: cfg_we with cfg_index 0 = grid_width, 1 = grid_height; write
//    only while no query is in flight.
// Timing:
//  - A write leaves the sequencer idle; the next request may follow right after.
//  - A query passes an init state, one walk state per straight step and, on a
//    diagonal step, the walk and two side-cell states (the two side cells and
//    the diagonal cell share one map read port), then a done state; the walk
//    stops early at a blocked or out-of-range cell.
//  - A new request is taken while an earlier result still waits at the output;
//    a query that finishes while the output is stalled holds until it drains.
// Reset: synchronous, active low. The map is then cleared one cell per cycle,
//  over 4**ceil(log2(MAX_SIDE)) cells (4096 by default), with in_stall high.
// ----------------------------------------------------------------------------
module grid_line_of_fire_check
  import grid_lof_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [RegW-1:0]   cfg_wdata,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [CoordW-1:0] in_cell_x,
  input  logic [CoordW-1:0] in_cell_y,
  input  logic              in_cell_blocks,
  input  logic [CoordW-1:0] in_from_x,
  input  logic [CoordW-1:0] in_from_y,
  input  logic [CoordW-1:0] in_to_x,
  input  logic [CoordW-1:0] in_to_y,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_line_clear
);

  cmd_t cmd;  // controller -> datapath
  sts_t sts;  // datapath -> controller

  // sequencer: clear pass, write/query dispatch, walk steps, result push
  grid_lof_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // map memory, walk state, size registers and output register
  grid_lof_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_blocks (in_cell_blocks),
    .in_from_x      (in_from_x),
    .in_from_y      (in_from_y),
    .in_to_x        (in_to_x),
    .in_to_y        (in_to_y),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_line_clear (out_line_clear),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
